### sv/four_channel_step_pulse_sequencer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the step pulse sequencer
// Shared property forms, clocked on clk_i and quiet while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_STEP_PULSE_SEQUENCER_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_STEP_PULSE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fcsp_pkg.sv
// ---------------------------------------------------------------------------
// fcsp_pkg
// Types, constants and helpers shared by the step pulse sequencer.
// ---------------------------------------------------------------------------
package fcsp_pkg;

  localparam int unsigned NumMotors     = 4;
  localparam int unsigned ChanBits      = $clog2(NumMotors);
  localparam int unsigned CountBitsDef  = 16;
  localparam int unsigned PeriodBitsDef = 16;
  localparam int unsigned QueueDepth    = 2;

  // direction codes
  localparam logic [1:0] DirHigh = 2'd0;
  localparam logic [1:0] DirLow  = 2'd1;
  localparam logic [1:0] DirKeep = 2'd2;
  localparam logic [1:0] DirHold = 2'd3;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } fcsp_req_e;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic      valid;
    fcsp_req_e kind;
  } fcsp_head_t;

  typedef struct packed {
    logic                found;
    logic [ChanBits-1:0] idx;
  } fcsp_pick_t;

  // lowest set bit
  function automatic fcsp_pick_t first_set(input logic [NumMotors-1:0] hits);
    fcsp_pick_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int c = NumMotors - 1; c >= 0; c--) begin
      if (hits[c]) begin
        r.found = 1'b1;
        r.idx   = ChanBits'(c);
      end
    end
    return r;
  endfunction

endpackage

### sv/fcsp_front.sv
// ---------------------------------------------------------------------------
// fcsp_front
// Accepts requests, decodes direction codes and period, and queues them.
// ---------------------------------------------------------------------------
module fcsp_front
  import fcsp_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = CountBitsDef,
  parameter int unsigned PERIOD_BITS = PeriodBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  req_type_i,
  input  logic [PERIOD_BITS-1:0]                half_period_i,
  input  logic [NumMotors-1:0][1:0]             dir_code_i,
  input  logic [NumMotors-1:0][COUNT_BITS-1:0]  count_i,
  input  logic                                  pop_i,
  output fcsp_head_t                            head_o,
  output logic [PERIOD_BITS-1:0]                hp_o,
  output logic [NumMotors-1:0]                  dir_set_o,
  output logic [NumMotors-1:0]                  dir_clr_o,
  output logic [NumMotors-1:0]                  nz_o,
  output logic [NumMotors-1:0][COUNT_BITS-1:0]  count_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillBits = $clog2(QueueDepth + 1);

  fcsp_req_e                           kind_mem_q [QueueDepth];
  logic [PERIOD_BITS-1:0]              hp_mem_q   [QueueDepth];
  logic [NumMotors-1:0]                set_mem_q  [QueueDepth];
  logic [NumMotors-1:0]                clr_mem_q  [QueueDepth];
  logic [NumMotors-1:0]                nz_mem_q   [QueueDepth];
  logic [NumMotors-1:0][COUNT_BITS-1:0] cnt_mem_q [QueueDepth];

  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillBits-1:0] fill_q, fill_d;
  logic                push;
  logic                pop;

  logic [PERIOD_BITS-1:0] hp_norm;
  logic [NumMotors-1:0]   dir_set, dir_clr, nz;

  always_comb begin
    for (int c = 0; c < NumMotors; c++) begin
      dir_set[c] = (dir_code_i[c] == DirHigh);
      dir_clr[c] = (dir_code_i[c] == DirLow);
      nz[c]      = (count_i[c] != '0);
    end
    // zero half period runs as one tick
    hp_norm = (half_period_i == '0) ? PERIOD_BITS'(1) : half_period_i;
  end

  assign in_ready_o = (fill_q != FillBits'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (fill_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_mem_q[wr_ptr_q] <= fcsp_req_e'(req_type_i);
      hp_mem_q[wr_ptr_q]   <= hp_norm;
      set_mem_q[wr_ptr_q]  <= dir_set;
      clr_mem_q[wr_ptr_q]  <= dir_clr;
      nz_mem_q[wr_ptr_q]   <= nz;
      cnt_mem_q[wr_ptr_q]  <= count_i;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.kind  = kind_mem_q[rd_ptr_q];
  assign hp_o         = hp_mem_q[rd_ptr_q];
  assign dir_set_o    = set_mem_q[rd_ptr_q];
  assign dir_clr_o    = clr_mem_q[rd_ptr_q];
  assign nz_o         = nz_mem_q[rd_ptr_q];
  assign count_o      = cnt_mem_q[rd_ptr_q];

endmodule

### sv/fcsp_back.sv
// ---------------------------------------------------------------------------
// fcsp_back
// Runs the pulse sequence one request per cycle while the result is not stalled, and registers the result.
// ---------------------------------------------------------------------------
module fcsp_back
  import fcsp_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = CountBitsDef,
  parameter int unsigned PERIOD_BITS = PeriodBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fcsp_head_t                            head_i,
  input  logic [PERIOD_BITS-1:0]                hp_i,
  input  logic [NumMotors-1:0]                  dir_set_i,
  input  logic [NumMotors-1:0]                  dir_clr_i,
  input  logic [NumMotors-1:0]                  nz_i,
  input  logic [NumMotors-1:0][COUNT_BITS-1:0]  count_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [NumMotors-1:0]                  dir_pins_o,
  output logic [NumMotors-1:0]                  step_pins_o,
  output logic                                  busy_res_o,
  output logic                                  move_done_o,
  output logic                                  rejected_o
);

  logic [NumMotors-1:0]                 dir_q, dir_d;
  logic [NumMotors-1:0]                 step_q, step_d;
  logic [NumMotors-1:0][COUNT_BITS-1:0] tgt_q, tgt_d;
  logic [COUNT_BITS-1:0]                pass_q, pass_d;
  logic [ChanBits-1:0]                  ch_q, ch_d;
  logic                                 phase_q, phase_d;
  logic [PERIOD_BITS-1:0]               wait_q, wait_d;
  logic [PERIOD_BITS-1:0]               hp_q, hp_d;
  logic                                 run_q, run_d;
  logic                                 done_q, done_d;
  logic                                 rej_q, rej_d;
  logic                                 ovld_q, ovld_d;

  logic                   pop;
  logic [COUNT_BITS-1:0]  pass_inc;
  logic [PERIOD_BITS-1:0] wait_dec;
  logic [NumMotors-1:0]   cur_hit, nxt_hit;
  fcsp_pick_t             pick_cur, pick_nxt, pick_cmd;

  assign pop      = head_i.valid && (!ovld_q || out_ready_i);
  assign pass_inc = pass_q + 1'b1;
  assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

  always_comb begin
    for (int c = 0; c < NumMotors; c++) begin
      cur_hit[c] = (pass_q < tgt_q[c]) && (ChanBits'(c) > ch_q);
      nxt_hit[c] = (pass_inc < tgt_q[c]);
    end
    pick_cur = first_set(cur_hit);
    pick_nxt = first_set(nxt_hit);
    pick_cmd = first_set(nz_i);
  end

  always_comb begin
    dir_d   = dir_q;
    step_d  = step_q;
    tgt_d   = tgt_q;
    pass_d  = pass_q;
    ch_d    = ch_q;
    phase_d = phase_q;
    wait_d  = wait_q;
    hp_d    = hp_q;
    run_d   = run_q;
    done_d  = done_q;
    rej_d   = rej_q;
    ovld_d  = ovld_q && !out_ready_i;
    if (pop) begin
      ovld_d = 1'b1;
      done_d = 1'b0;
      rej_d  = 1'b0;
      unique case (head_i.kind)
        REQ_START: begin
          if (run_q) begin
            rej_d = 1'b1;
          end else begin
            dir_d  = (dir_q & ~dir_clr_i) | dir_set_i;
            tgt_d  = count_i;
            hp_d   = hp_i;
            pass_d = '0;
            step_d = '0;
            if (pick_cmd.found) begin
              run_d   = 1'b1;
              ch_d    = pick_cmd.idx;
              step_d  = NumMotors'(1) << pick_cmd.idx;
              phase_d = 1'b0;
              wait_d  = hp_i;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        REQ_TICK: begin
          if (run_q) begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              if (!phase_q) begin
                step_d  = step_q & ~(NumMotors'(1) << ch_q);
                phase_d = 1'b1;
                wait_d  = hp_q;
              end else if (pick_cur.found) begin
                ch_d    = pick_cur.idx;
                step_d  = step_q | (NumMotors'(1) << pick_cur.idx);
                phase_d = 1'b0;
                wait_d  = hp_q;
              end else begin
                pass_d = pass_inc;
                if (pick_nxt.found) begin
                  ch_d    = pick_nxt.idx;
                  step_d  = step_q | (NumMotors'(1) << pick_nxt.idx);
                  phase_d = 1'b0;
                  wait_d  = hp_q;
                end else begin
                  run_d   = 1'b0;
                  phase_d = 1'b0;
                  wait_d  = '0;
                  done_d  = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= '0;
      step_q  <= '0;
      tgt_q   <= '0;
      pass_q  <= '0;
      ch_q    <= '0;
      phase_q <= 1'b0;
      wait_q  <= '0;
      hp_q    <= '0;
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      rej_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      step_q  <= step_d;
      tgt_q   <= tgt_d;
      pass_q  <= pass_d;
      ch_q    <= ch_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      hp_q    <= hp_d;
      run_q   <= run_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
      ovld_q  <= ovld_d;
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = ovld_q;
  assign dir_pins_o  = dir_q;
  assign step_pins_o = step_q;
  assign busy_res_o  = run_q;
  assign move_done_o = done_q;
  assign rejected_o  = rej_q;

endmodule

### sv/four_channel_step_pulse_sequencer_unit.sv
// ---------------------------------------------------------------------------
// four_channel_step_pulse_sequencer_unit
// Step/direction pulse sequencer for four stepper drivers.
//
//   Port group   Dir  Handshake              Carries
//   request      in   in_valid_i/in_ready_o  req_type, half_period, dir codes, counts
//   result       out  out_valid_o/out_ready_i dir/step pins, busy, done, rejected
//
// One request per cycle sustained while results are taken; a result is registered after
// acceptance through the queue write, then the sequencer update into the result register.
// Two-entry queue between decode and sequencer; in_ready_o drops only when full.
// Reset clears pins, counts and queue at once; no clearing pass.
// A stalled result holds the sequencer; the queue keeps taking requests until full.
// ---------------------------------------------------------------------------
`include "four_channel_step_pulse_sequencer_unit_defines.svh"

module four_channel_step_pulse_sequencer_unit
  import fcsp_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = CountBitsDef,
  parameter int unsigned PERIOD_BITS = PeriodBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [PERIOD_BITS-1:0] half_period_i,
  input  logic [1:0]             dir_code_1_i,
  input  logic [1:0]             dir_code_2_i,
  input  logic [1:0]             dir_code_3_i,
  input  logic [1:0]             dir_code_4_i,
  input  logic [COUNT_BITS-1:0]  count_1_i,
  input  logic [COUNT_BITS-1:0]  count_2_i,
  input  logic [COUNT_BITS-1:0]  count_3_i,
  input  logic [COUNT_BITS-1:0]  count_4_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             dir_pins_o,
  output logic [3:0]             step_pins_o,
  output logic                   busy_res_o,
  output logic                   move_done_o,
  output logic                   rejected_o
);

  logic [NumMotors-1:0][1:0]            dir_code;
  logic [NumMotors-1:0][COUNT_BITS-1:0] count_in;
  logic [NumMotors-1:0][COUNT_BITS-1:0] count_q;
  logic [PERIOD_BITS-1:0]               hp;
  logic [NumMotors-1:0]                 dir_set, dir_clr, nz;
  fcsp_head_t                           head;
  logic                                 pop;

  assign dir_code[0] = dir_code_1_i;
  assign dir_code[1] = dir_code_2_i;
  assign dir_code[2] = dir_code_3_i;
  assign dir_code[3] = dir_code_4_i;
  assign count_in[0] = count_1_i;
  assign count_in[1] = count_2_i;
  assign count_in[2] = count_3_i;
  assign count_in[3] = count_4_i;

  fcsp_front #(
    .COUNT_BITS (COUNT_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .half_period_i(half_period_i),
    .dir_code_i   (dir_code),
    .count_i      (count_in),
    .pop_i        (pop),
    .head_o       (head),
    .hp_o         (hp),
    .dir_set_o    (dir_set),
    .dir_clr_o    (dir_clr),
    .nz_o         (nz),
    .count_o      (count_q)
  );

  fcsp_back #(
    .COUNT_BITS (COUNT_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .hp_i       (hp),
    .dir_set_i  (dir_set),
    .dir_clr_i  (dir_clr),
    .nz_i       (nz),
    .count_i    (count_q),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dir_pins_o (dir_pins_o),
    .step_pins_o(step_pins_o),
    .busy_res_o (busy_res_o),
    .move_done_o(move_done_o),
    .rejected_o (rejected_o)
  );

  // at most one step pin high, and only while a move runs
  `FCSP_ASSERT_IMP(a_step_onehot, 1'b1, $onehot0(step_pins_o), "several step pins high")
  `FCSP_ASSERT_IMP(a_step_idle, !busy_res_o, step_pins_o == '0, "step pin high while idle")
  `FCSP_ASSERT_IMP(a_rej_busy, out_valid_o && rejected_o, busy_res_o && !move_done_o,
                   "reject outside a running move")
  `FCSP_ASSERT_IMP(a_done_idle, out_valid_o && move_done_o, !busy_res_o,
                   "move done while still busy")
  `FCSP_ASSERT_NXT(a_busy_hold, busy_res_o && !pop, busy_res_o, "busy dropped without a request")

endmodule

### test/four_channel_step_pulse_sequencer_unit_checker.sv
// ---------------------------------------------------------------------------
// Step pulse sequencer checker
// Watches both channels of the sequencer. Each accepted request is run
// through an independent model of the pin sequencing. The pin state that it
// predicts is queued and compared, field by field, with the next result taken.
// Mismatches and results that arrive with nothing queued are counted and
// passed up to the testbench top.
// ---------------------------------------------------------------------------
module four_channel_step_pulse_sequencer_unit_checker
  import fcsp_pkg::*;
(
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   req_valid_i,
  input  logic                                   req_ready_i,
  input  logic                                   req_type_i,
  input  logic [PeriodBitsDef-1:0]               half_period_i,
  input  logic [NumMotors-1:0][1:0]              dir_code_i,
  input  logic [NumMotors-1:0][CountBitsDef-1:0] count_i,
  input  logic                                   res_valid_i,
  input  logic                                   res_ready_i,
  input  logic [3:0]                             dir_pins_i,
  input  logic [3:0]                             step_pins_i,
  input  logic                                   busy_res_i,
  input  logic                                   move_done_i,
  input  logic                                   rejected_i,
  output int                                     error_count_o,
  output int                                     pending_o,
  output logic                                   move_active_o,
  output int                                     result_count_o,
  output int                                     start_count_o,
  output int                                     done_count_o,
  output int                                     refuse_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    fcsp_req_e                              kind;
    logic [PeriodBitsDef-1:0]               half_period;
    logic [NumMotors-1:0][1:0]              dir_code;
    logic [NumMotors-1:0][CountBitsDef-1:0] count;
  } step_request_t;

  typedef struct packed {
    logic [3:0] dir_pins;
    logic [3:0] step_pins;
    logic       busy;
    logic       done;
    logic       rejected;
  } pin_state_t;

  // sequencer model
  logic [3:0]                             dir_lvl;
  logic [3:0]                             step_lvl;
  logic [NumMotors-1:0][CountBitsDef-1:0] target;
  logic [CountBitsDef-1:0]                pass_idx;
  int unsigned                            cur_motor;
  logic                                   low_phase;
  logic [PeriodBitsDef-1:0]               wait_cnt;
  logic [PeriodBitsDef-1:0]               half_hold;
  logic                                   moving;

  pin_state_t    pins_expected[$];
  step_request_t req_now;
  pin_state_t    want_now;
  pin_state_t    head;
  int            mismatch_n;
  int            result_n;
  int            start_n;
  int            done_n;
  int            refuse_n;

  // first motor at or after 'from' with a step left in this pass
  function automatic int unsigned next_motor(input int unsigned from,
                                             input logic [CountBitsDef-1:0] pass);
    int unsigned m;
    for (m = from; m < NumMotors; m++) begin
      if (pass < target[m]) return m;
    end
    return NumMotors;
  endfunction

  task automatic start_pulse(input int unsigned m);
    cur_motor   = m;
    step_lvl[m] = 1'b1;
    low_phase   = 1'b0;
    wait_cnt    = half_hold;
  endtask

  task automatic apply_request(input step_request_t r, output pin_state_t p);
    int unsigned m;
    int          k;
    logic        fin;
    logic        refused;
    fin     = 1'b0;
    refused = 1'b0;
    if (r.kind == REQ_START) begin
      if (moving) begin
        refused = 1'b1;
      end else begin
        for (k = 0; k < NumMotors; k++) begin
          if (r.dir_code[k] == DirHigh) dir_lvl[k] = 1'b1;
          else if (r.dir_code[k] == DirLow) dir_lvl[k] = 1'b0;
          target[k] = r.count[k];
        end
        half_hold = (r.half_period == '0) ? PeriodBitsDef'(1) : r.half_period;
        pass_idx  = '0;
        step_lvl  = '0;
        m = next_motor(0, '0);
        if (m < NumMotors) begin
          moving = 1'b1;
          start_pulse(m);
        end else begin
          fin = 1'b1;
        end
      end
    end else if (moving) begin
      if (wait_cnt != '0) wait_cnt--;
      if (wait_cnt == '0) begin
        if (!low_phase) begin
          step_lvl[cur_motor] = 1'b0;
          low_phase           = 1'b1;
          wait_cnt            = half_hold;
        end else begin
          m = next_motor(cur_motor + 1, pass_idx);
          if (m >= NumMotors) begin
            pass_idx++;
            m = next_motor(0, pass_idx);
          end
          if (m < NumMotors) begin
            start_pulse(m);
          end else begin
            moving    = 1'b0;
            low_phase = 1'b0;
            wait_cnt  = '0;
            fin       = 1'b1;
          end
        end
      end
    end
    p.dir_pins  = dir_lvl;
    p.step_pins = step_lvl;
    p.busy      = moving;
    p.done      = fin;
    p.rejected  = refused;
  endtask

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_n++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_lvl    = '0;
      step_lvl   = '0;
      target     = '0;
      pass_idx   = '0;
      cur_motor  = 0;
      low_phase  = 1'b0;
      wait_cnt   = '0;
      half_hold  = '0;
      moving     = 1'b0;
      mismatch_n = 0;
      result_n   = 0;
      start_n    = 0;
      done_n     = 0;
      refuse_n   = 0;
      pins_expected.delete();
    end else begin
      if (req_valid_i && req_ready_i) begin
        req_now.kind        = fcsp_req_e'(req_type_i);
        req_now.half_period = half_period_i;
        req_now.dir_code    = dir_code_i;
        req_now.count       = count_i;
        apply_request(req_now, want_now);
        pins_expected.push_back(want_now);
        if (req_now.kind == REQ_START && !want_now.rejected) start_n++;
        if (want_now.done) done_n++;
        if (want_now.rejected) refuse_n++;
      end
      if (res_valid_i && res_ready_i) begin
        result_n++;
        if (pins_expected.size() == 0) begin
          $error("result taken with no request outstanding");
          mismatch_n++;
        end else begin
          head = pins_expected.pop_front();
          check_field("dir_pins", head.dir_pins, dir_pins_i);
          check_field("step_pins", head.step_pins, step_pins_i);
          check_field("busy_res", head.busy, busy_res_i);
          check_field("move_done", head.done, move_done_i);
          check_field("rejected", head.rejected, rejected_i);
        end
      end
    end
    error_count_o  <= mismatch_n;
    pending_o      <= pins_expected.size();
    move_active_o  <= moving;
    result_count_o <= result_n;
    start_count_o  <= start_n;
    done_count_o   <= done_n;
    refuse_count_o <= refuse_n;
  end

endmodule

### test/four_channel_step_pulse_sequencer_unit_test.sv
// ---------------------------------------------------------------------------
// Step pulse sequencer testbench
// Drives tick and move requests into the sequencer with random gaps and
// random result back-pressure, including one long hold that fills the
// request queue. A directed opening covers zero counts, zero half period,
// requests refused while busy and a slow pulse; random moves follow, and the
// run ends on a move with every count and the half period at full scale.
// ---------------------------------------------------------------------------
module four_channel_step_pulse_sequencer_unit_test
  import fcsp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_ready_o;
  logic                                   req_type_i;
  logic [PeriodBitsDef-1:0]               half_period_i;
  logic [NumMotors-1:0][1:0]              dir_code;
  logic [NumMotors-1:0][CountBitsDef-1:0] count;
  logic                                   out_valid_o;
  logic                                   out_ready_i;
  logic [3:0]                             dir_pins_o;
  logic [3:0]                             step_pins_o;
  logic                                   busy_res_o;
  logic                                   move_done_o;
  logic                                   rejected_o;

  int   error_count;
  int   pending;
  logic move_active;
  int   result_count;
  int   start_count;
  int   done_count;
  int   refuse_count;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  four_channel_step_pulse_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .half_period_i (half_period_i),
    .dir_code_1_i  (dir_code[0]),
    .dir_code_2_i  (dir_code[1]),
    .dir_code_3_i  (dir_code[2]),
    .dir_code_4_i  (dir_code[3]),
    .count_1_i     (count[0]),
    .count_2_i     (count[1]),
    .count_3_i     (count[2]),
    .count_4_i     (count[3]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dir_pins_o    (dir_pins_o),
    .step_pins_o   (step_pins_o),
    .busy_res_o    (busy_res_o),
    .move_done_o   (move_done_o),
    .rejected_o    (rejected_o)
  );

  four_channel_step_pulse_sequencer_unit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_i    (in_ready_o),
    .req_type_i     (req_type_i),
    .half_period_i  (half_period_i),
    .dir_code_i     (dir_code),
    .count_i        (count),
    .res_valid_i    (out_valid_o),
    .res_ready_i    (out_ready_i),
    .dir_pins_i     (dir_pins_o),
    .step_pins_i    (step_pins_o),
    .busy_res_i     (busy_res_o),
    .move_done_i    (move_done_o),
    .rejected_i     (rejected_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .move_active_o  (move_active),
    .result_count_o (result_count),
    .start_count_o  (start_count),
    .done_count_o   (done_count),
    .refuse_count_o (refuse_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_request(input fcsp_req_e kind,
                              input logic [PeriodBitsDef-1:0] hp,
                              input logic [NumMotors-1:0][1:0] codes,
                              input logic [NumMotors-1:0][CountBitsDef-1:0] counts);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    half_period_i <= hp;
    dir_code      <= codes;
    count         <= counts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // tick request; the other fields carry noise
  task automatic tick();
    send_request(REQ_TICK, 16'($urandom), 8'($urandom), {$urandom, $urandom});
  endtask

  task automatic run_out();
    do tick(); while (move_active);
  endtask

  task automatic send_move(input int unsigned max_count, input int unsigned max_hp);
    logic [NumMotors-1:0][1:0]              codes;
    logic [NumMotors-1:0][CountBitsDef-1:0] counts;
    int                                     k;
    for (k = 0; k < NumMotors; k++) begin
      codes[k]  = 2'($urandom_range(0, 3));
      counts[k] = CountBitsDef'($urandom_range(0, max_count));
    end
    send_request(REQ_START, PeriodBitsDef'($urandom_range(0, max_hp)), codes, counts);
  endtask

  // result side: random short stalls, plus one long hold on request
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    req_type_i    <= REQ_TICK;
    half_period_i <= '0;
    dir_code      <= '0;
    count         <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    tick();
    send_request(REQ_START, 16'd5, {DirHold, DirKeep, DirLow, DirHigh}, '0);
    send_request(REQ_START, 16'd0, {4{DirHigh}}, {16'd2, 16'd0, 16'd1, 16'd3});
    send_request(REQ_START, 16'hFFFF, {4{DirLow}}, {4{16'hFFFF}});
    run_out();
    send_request(REQ_START, 16'd2, {DirLow, DirHigh, DirHold, DirKeep},
                 {16'd1, 16'd0, 16'd0, 16'd0});
    run_out();
    send_request(REQ_START, 16'd300, {DirHigh, DirLow, DirHigh, DirLow},
                 {16'd0, 16'd1, 16'd0, 16'd0});
    run_out();
    send_request(REQ_START, 16'd1, {DirKeep, DirKeep, DirLow, DirLow}, {4{16'd2}});
    run_out();

    // random
    for (n = 0; n < 1400; n++) begin
      if (n == 350) hold_req = 1'b1;
      if (n == 700) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      if (n == 1200) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 9) == 0) send_move(12, 20);
        else send_move(4, 3);
      end else begin
        tick();
      end
    end

    // full-scale move, left running
    run_out();
    send_request(REQ_START, 16'hFFFF, {DirLow, DirHigh, DirLow, DirHigh}, {4{16'hFFFF}});
    repeat (300) tick();
    send_move(4, 3);
    repeat (20) tick();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d requests: %0d moves started, %0d finished, %0d refused busy.",
             result_count, start_count, done_count, refuse_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### four_channel_step_pulse_sequencer_unit.f
+incdir+sv
sv/fcsp_pkg.sv
sv/fcsp_front.sv
sv/fcsp_back.sv
sv/four_channel_step_pulse_sequencer_unit.sv
test/four_channel_step_pulse_sequencer_unit_checker.sv
test/four_channel_step_pulse_sequencer_unit_test.sv
